@@ hdl/cpu8_instruction_execute_defines.svh @@
// Assertion macros shared by the execute unit's RTL.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef CPU8_INSTRUCTION_EXECUTE_DEFINES_SVH
`define CPU8_INSTRUCTION_EXECUTE_DEFINES_SVH

// Implication checked on every rising edge of clk, outside reset.
`define CPU8_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, but also active while reset is held.
`define CPU8_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/cpu8ie_pkg.sv @@
// Package for the 8-bit execute unit: request/response types, opcodes, constants.
// Used by cpu8ie_exec and cpu8_instruction_execute.
`default_nettype none
package cpu8ie_pkg;

  localparam int MaxWrites = 3;

  localparam logic [7:0] STACK_PAGE = 8'h01;
  localparam logic [7:0] PUSH_MASK  = 8'h30;

  typedef struct packed {
    logic [5:0]  operation;
    logic [7:0]  operand_byte;
    logic [15:0] effective_address;
    logic        accumulator_mode;
    logic [15:0] fallthrough_pc;
    logic [7:0]  pull_first;
    logic [7:0]  pull_second;
    logic [7:0]  pull_third;
    logic [15:0] break_vector;
  } req_t;

  typedef struct packed {
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        last_of_run;
    logic [15:0] next_pc;
    logic [7:0]  accumulator;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  stack_pointer;
    logic [7:0]  flags;
  } rsp_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } regs_t;

  typedef enum logic [5:0] {
    OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
    OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
    OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BRK = 6'd10, OP_BVC = 6'd11,
    OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14, OP_CLI = 6'd15,
    OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
    OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23,
    OP_INC = 6'd24, OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27,
    OP_JSR = 6'd28, OP_LDA = 6'd29, OP_LDX = 6'd30, OP_LDY = 6'd31,
    OP_LSR = 6'd32, OP_NOP = 6'd33, OP_ORA = 6'd34, OP_PHA = 6'd35,
    OP_PHP = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_ROL = 6'd39,
    OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SBC = 6'd43,
    OP_SEC = 6'd44, OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47,
    OP_STX = 6'd48, OP_STY = 6'd49, OP_TAX = 6'd50, OP_TAY = 6'd51,
    OP_TSX = 6'd52, OP_TXA = 6'd53, OP_TXS = 6'd54, OP_TYA = 6'd55
  } op_t;

  // Status bit positions.
  localparam int FL_C = 0;
  localparam int FL_Z = 1;
  localparam int FL_I = 2;
  localparam int FL_D = 3;
  localparam int FL_V = 6;
  localparam int FL_N = 7;

endpackage
`default_nettype wire

@@ hdl/cpu8ie_exec.sv @@
// Combinational execute logic: one instruction against the current registers.
// Depends on cpu8ie_pkg; produces the new registers and up to three results.
`default_nettype none
module cpu8ie_exec (
  input  wire cpu8ie_pkg::req_t  req,
  input  wire cpu8ie_pkg::regs_t cur,
  output cpu8ie_pkg::regs_t      nxt,
  output cpu8ie_pkg::rsp_t       res [cpu8ie_pkg::MaxWrites],
  output logic [1:0]             res_count
);
  import cpu8ie_pkg::*;

  logic [1:0]  nw;
  logic [15:0] waddr [MaxWrites];
  logic [7:0]  wdata [MaxWrites];
  logic [15:0] pc;
  logic [7:0]  p, a, x, y, sp, m, st;
  logic [9:0]  dsum;
  logic [15:0] dif;
  logic [8:0]  mb;
  logic [7:0]  rin, rout;
  logic [15:0] jpc;
  logic        cin, bin;

  always_comb begin
    a = cur.a; x = cur.x; y = cur.y; sp = cur.sp; p = cur.p; st = cur.p;
    m = req.operand_byte;
    pc = req.fallthrough_pc;
    nw = 2'd0;
    cin = cur.p[FL_C];
    bin = ~cur.p[FL_C];
    dsum = 10'd0; dif = 16'd0; mb = 9'd0; rin = 8'd0; rout = 8'd0; jpc = 16'd0;
    for (int i = 0; i < MaxWrites; i++) begin
      waddr[i] = 16'h0000;
      wdata[i] = 8'h00;
    end
    case (req.operation)
      OP_ADC: begin
        dsum = {2'b00, a} + {2'b00, m} + {9'd0, cin};
        p[FL_Z] = (dsum[7:0] == 8'h00);
        if (cur.p[FL_D]) begin
          if ({1'b0, a[3:0]} + {1'b0, m[3:0]} + {4'd0, cin} > 5'd9) dsum = dsum + 10'd6;
          p[FL_N] = dsum[7];
          p[FL_V] = (a[7] ^ dsum[7]) & (m[7] ^ dsum[7]);
          if (dsum > 10'h099) dsum = dsum + 10'h060;
          p[FL_C] = (dsum > 10'h099);
        end else begin
          p[FL_N] = dsum[7];
          p[FL_C] = dsum[8];
          p[FL_V] = (a[7] ^ dsum[7]) & (m[7] ^ dsum[7]);
        end
        a = dsum[7:0];
      end
      OP_SBC: begin
        mb = {1'b0, m} + {8'd0, bin};
        dif = {8'h00, a} - {8'h00, m} - {15'd0, bin};
        p[FL_N] = dif[7];
        p[FL_Z] = (dif[7:0] == 8'h00);
        p[FL_V] = (a[7] ^ m[7]) & (a[7] ^ dif[7]);
        p[FL_C] = ({1'b0, a} >= mb);
        if (cur.p[FL_D]) begin
          if ({1'b0, a[3:0]} < {1'b0, m[3:0]} + {4'd0, bin}) dif = dif - 16'd6;
          if (dif > 16'h0099) dif = dif - 16'h0060;
        end
        a = dif[7:0];
      end
      OP_AND: begin a = a & m; p[FL_N] = a[7]; p[FL_Z] = (a == 8'h00); end
      OP_ORA: begin a = a | m; p[FL_N] = a[7]; p[FL_Z] = (a == 8'h00); end
      OP_EOR: begin a = a ^ m; p[FL_N] = a[7]; p[FL_Z] = (a == 8'h00); end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_DEC, OP_INC: begin
        rin = (req.accumulator_mode && req.operation != OP_INC) ? a : m;
        case (req.operation)
          OP_ASL: begin p[FL_C] = rin[7]; rout = {rin[6:0], 1'b0}; end
          OP_LSR: begin p[FL_C] = rin[0]; rout = {1'b0, rin[7:1]}; end
          OP_ROL: begin p[FL_C] = rin[7]; rout = {rin[6:0], cin}; end
          OP_ROR: begin p[FL_C] = rin[0]; rout = {cin, rin[7:1]}; end
          OP_DEC: rout = rin - 8'd1;
          default: rout = rin + 8'd1;
        endcase
        p[FL_N] = rout[7];
        p[FL_Z] = (rout == 8'h00);
        if (req.accumulator_mode && req.operation != OP_INC) begin
          a = rout;
        end else begin
          nw = 2'd1;
          waddr[0] = req.effective_address;
          wdata[0] = rout;
        end
      end
      OP_BCC: if (!st[FL_C]) pc = req.effective_address;
      OP_BCS: if (st[FL_C]) pc = req.effective_address;
      OP_BEQ: if (st[FL_Z]) pc = req.effective_address;
      OP_BMI: if (st[FL_N]) pc = req.effective_address;
      OP_BNE: if (!st[FL_Z]) pc = req.effective_address;
      OP_BPL: if (!st[FL_N]) pc = req.effective_address;
      OP_BVC: if (!st[FL_V]) pc = req.effective_address;
      OP_BVS: if (st[FL_V]) pc = req.effective_address;
      OP_BIT: begin
        p[FL_N] = m[7]; p[FL_V] = m[6]; p[FL_Z] = ((a & m) == 8'h00);
      end
      OP_BRK: begin
        nw = 2'd3;
        waddr[0] = {STACK_PAGE, sp};         wdata[0] = req.fallthrough_pc[15:8];
        waddr[1] = {STACK_PAGE, sp - 8'd1};  wdata[1] = req.fallthrough_pc[7:0];
        waddr[2] = {STACK_PAGE, sp - 8'd2};  wdata[2] = st | PUSH_MASK;
        sp = sp - 8'd3;
        p[FL_I] = 1'b1;
        pc = req.break_vector;
      end
      OP_CLC: p[FL_C] = 1'b0;
      OP_CLD: p[FL_D] = 1'b0;
      OP_CLI: p[FL_I] = 1'b0;
      OP_CLV: p[FL_V] = 1'b0;
      OP_SEC: p[FL_C] = 1'b1;
      OP_SED: p[FL_D] = 1'b1;
      OP_SEI: p[FL_I] = 1'b1;
      OP_CMP, OP_CPX, OP_CPY: begin
        rin = (req.operation == OP_CMP) ? a : (req.operation == OP_CPX) ? x : y;
        rout = rin - m;
        p[FL_C] = (rin >= m);
        p[FL_N] = rout[7];
        p[FL_Z] = (rin == m);
      end
      OP_DEX: begin x = x - 8'd1; p[FL_N] = x[7]; p[FL_Z] = (x == 8'h00); end
      OP_DEY: begin y = y - 8'd1; p[FL_N] = y[7]; p[FL_Z] = (y == 8'h00); end
      OP_INX: begin x = x + 8'd1; p[FL_N] = x[7]; p[FL_Z] = (x == 8'h00); end
      OP_INY: begin y = y + 8'd1; p[FL_N] = y[7]; p[FL_Z] = (y == 8'h00); end
      OP_JMP: pc = req.effective_address;
      OP_JSR: begin
        jpc = req.fallthrough_pc - 16'd1;
        nw = 2'd2;
        waddr[0] = {STACK_PAGE, sp};        wdata[0] = jpc[15:8];
        waddr[1] = {STACK_PAGE, sp - 8'd1}; wdata[1] = jpc[7:0];
        sp = sp - 8'd2;
        pc = req.effective_address;
      end
      OP_LDA: begin a = m; p[FL_N] = m[7]; p[FL_Z] = (m == 8'h00); end
      OP_LDX: begin x = m; p[FL_N] = m[7]; p[FL_Z] = (m == 8'h00); end
      OP_LDY: begin y = m; p[FL_N] = m[7]; p[FL_Z] = (m == 8'h00); end
      OP_PHA: begin
        nw = 2'd1; waddr[0] = {STACK_PAGE, sp}; wdata[0] = a; sp = sp - 8'd1;
      end
      OP_PHP: begin
        nw = 2'd1; waddr[0] = {STACK_PAGE, sp}; wdata[0] = st | PUSH_MASK;
        sp = sp - 8'd1;
      end
      OP_PLA: begin
        a = req.pull_first; sp = sp + 8'd1;
        p[FL_N] = a[7]; p[FL_Z] = (a == 8'h00);
      end
      OP_PLP: begin p = req.pull_first; sp = sp + 8'd1; end
      OP_RTI: begin
        p = req.pull_first;
        pc = {req.pull_third, req.pull_second};
        sp = sp + 8'd3;
      end
      OP_RTS: begin
        pc = {req.pull_second, req.pull_first} + 16'd1;
        sp = sp + 8'd2;
      end
      OP_STA: begin nw = 2'd1; waddr[0] = req.effective_address; wdata[0] = a; end
      OP_STX: begin nw = 2'd1; waddr[0] = req.effective_address; wdata[0] = x; end
      OP_STY: begin nw = 2'd1; waddr[0] = req.effective_address; wdata[0] = y; end
      OP_TAX: begin x = a; p[FL_N] = x[7]; p[FL_Z] = (x == 8'h00); end
      OP_TAY: begin y = a; p[FL_N] = y[7]; p[FL_Z] = (y == 8'h00); end
      OP_TSX: begin x = sp; p[FL_N] = x[7]; p[FL_Z] = (x == 8'h00); end
      OP_TXA: begin a = x; p[FL_N] = a[7]; p[FL_Z] = (a == 8'h00); end
      OP_TXS: sp = x;
      OP_TYA: begin a = y; p[FL_N] = a[7]; p[FL_Z] = (a == 8'h00); end
      default: ;
    endcase
  end

  assign nxt = '{a: a, x: x, y: y, sp: sp, p: p};
  assign res_count = (nw == 2'd0) ? 2'd1 : nw;

  always_comb begin
    for (int i = 0; i < MaxWrites; i++) begin
      res[i] = '0;
      res[i].write_enable  = (2'(i) < nw);
      res[i].write_address = waddr[i];
      res[i].write_data    = wdata[i];
      if (2'(i) == res_count - 2'd1) begin
        res[i].last_of_run   = 1'b1;
        res[i].next_pc       = pc;
        res[i].accumulator   = a;
        res[i].index_x       = x;
        res[i].index_y       = y;
        res[i].stack_pointer = sp;
        res[i].flags         = p;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/cpu8_instruction_execute.sv @@
// Latency: a request's first result is presented the cycle after it is accepted.
// Throughput: one request per cycle while each needs one result and rsp_stall is low; a
// request with n memory writes (pushes, stores, read-modify-write) fills n buffer slots.
// Reset: A, X, Y and status clear to zero, SP goes to 0xFF, the result buffer empties.
// Depends on cpu8ie_pkg, cpu8ie_exec and cpu8_instruction_execute_defines.svh.
`default_nettype none
module cpu8_instruction_execute (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    req_valid,
  output logic                   req_stall,
  input  wire cpu8ie_pkg::req_t  req,
  output logic                   rsp_valid,
  input  wire                    rsp_stall,
  output cpu8ie_pkg::rsp_t       rsp
);
  import cpu8ie_pkg::*;
  `include "cpu8_instruction_execute_defines.svh"

  // Architectural registers, updated as soon as a request is accepted so the
  // very next request sees them.
  regs_t      regs;
  regs_t      regs_next;

  // Result buffer: all results of one instruction, drained in order.
  rsp_t       buf_q [MaxWrites];
  rsp_t       ex_res [MaxWrites];
  logic [1:0] ex_count;
  logic [1:0] count;
  logic [1:0] head;

  logic       req_fire;
  logic       rsp_fire;

  cpu8ie_exec u_exec (
    .req       (req),
    .cur       (regs),
    .nxt       (regs_next),
    .res       (ex_res),
    .res_count (ex_count)
  );

  assign rsp_valid = (count != 2'd0);
  assign rsp       = buf_q[head];
  assign rsp_fire  = rsp_valid && !rsp_stall;
  // A new request may enter when the buffer is empty or its last result leaves now.
  assign req_stall = !((count == 2'd0) || (count == 2'd1 && !rsp_stall));
  assign req_fire  = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs  <= '{a: 8'h00, x: 8'h00, y: 8'h00, sp: 8'hFF, p: 8'h00};
      count <= 2'd0;
      head  <= 2'd0;
    end else if (req_fire) begin
      regs  <= regs_next;
      count <= ex_count;
      head  <= 2'd0;
    end else if (rsp_fire) begin
      count <= count - 2'd1;
      head  <= head + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      buf_q <= ex_res;
    end
  end

  // The buffered result at the head is the final one exactly when one remains.
  `CPU8_ASSERT(a_last_matches_count, rsp_valid |-> (rsp.last_of_run == (count == 2'd1)),
    "last_of_run disagrees with buffer occupancy")
  // Every result before the final one is a memory write.
  `CPU8_ASSERT(a_early_is_write, (rsp_valid && !rsp.last_of_run) |-> rsp.write_enable,
    "non-final result without a write")
  // Accepting a request always leaves results pending.
  `CPU8_ASSERT(a_fire_fills, req_fire |=> rsp_valid, "accepted request left no result")

endmodule
`default_nettype wire
